// ----- rtl/core/gncl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gncl_pkg
// Shared types and constants for the grammar next-category lookup block.
// ----------------------------------------------------------------------------
package gncl_pkg;

    localparam int DEF_NUM_STATES     = 256;
    localparam int DEF_NUM_CATEGORIES = 256;
    localparam int DEF_MAX_ARCS       = 8;

    // Command codes carried in tuser of the input stream
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_NOISE  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_RD,
        ST_APP_WR,
        ST_FLAG,
        ST_RESP,
        ST_Q_CNT,
        ST_Q_CNT_W,
        ST_Q_ARC,
        ST_Q_LAB,
        ST_Q_CLS,
        ST_Q_NCNT,
        ST_Q_NARC,
        ST_Q_NDAT,
        ST_Q_FIN
    } t_gncl_state;

endpackage : gncl_pkg
`default_nettype wire

// ----- rtl/core/grammar_next_category_lookup_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grammar_next_category_lookup_top
// Grammar automaton store with append, noise-flag and next-category query.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_axis_tready is low while an item is in work.
// Append steps through ST_APP_RD, ST_APP_WR and ST_RESP, a noise-flag write
// through ST_FLAG and ST_RESP, and an unused command goes straight to
// ST_RESP, which loads the result into the output register. A query reads
// the arc count, then walks the arcs of the queried state; an arc with a
// noise label is expanded into the arcs of its target state. The walk uses the
// single read port of the arc memory, which the sequencer visits once per
// arc with a registered read. Results leave through a one-deep output
// register; a stalled output stalls the sequencer. The last result of each
// item carries tlast. Arc memories are not cleared; only entries below a
// state's arc count are ever read.
// ----------------------------------------------------------------------------
module grammar_next_category_lookup_top
    import gncl_pkg::*;
#(
    parameter int NUM_STATES     = DEF_NUM_STATES,
    parameter int NUM_CATEGORIES = DEF_NUM_CATEGORIES,
    parameter int MAX_ARCS       = DEF_MAX_ARCS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // state_id[7:0], category[15:8], target_state[23:16], noise[24], zero pad
    input  wire logic [31:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_category[7:0], out_next_state[15:8]
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    // empty_res[0], status[1]
    output logic [1:0]       m_axis_tuser
);

    localparam int NS_EFF    = (NUM_STATES < 256) ? NUM_STATES : 256;
    localparam int NC_EFF    = (NUM_CATEGORIES < 256) ? NUM_CATEGORIES : 256;
    localparam int SID_W     = $clog2(NS_EFF);
    localparam int CAT_W     = $clog2(NC_EFF);
    localparam int CNT_W     = $clog2(MAX_ARCS + 1);
    localparam int ARC_DEPTH = NS_EFF * MAX_ARCS;
    localparam int ADDR_W    = $clog2(ARC_DEPTH);

    function automatic logic [ADDR_W-1:0] f_arc_addr(input logic [SID_W-1:0] st,
                                                     input logic [CNT_W-1:0] idx);
        return ADDR_W'(st) * ADDR_W'(MAX_ARCS) + ADDR_W'(idx);
    endfunction

    function automatic logic f_sid_ok(input logic [7:0] s);
        return {24'd0, s} < 32'(NS_EFF);
    endfunction

    function automatic logic f_cat_ok(input logic [7:0] c);
        return {24'd0, c} < 32'(NC_EFF);
    endfunction

    // Storage
    logic [15:0]      mem_arc [ARC_DEPTH];   // {target, label}
    logic [CNT_W-1:0] mem_cnt [NS_EFF];
    logic [NS_EFF-1:0] r_cnt_vld;
    logic [NC_EFF-1:0] r_noise;

    // Sequencer
    t_gncl_state r_state, n_state;

    // Latched item
    logic [1:0]       r_cmd;
    logic [7:0]       r_sid, r_cat, r_tgt;
    logic             r_nz;
    logic             r_stat;

    // Walk registers
    logic [CNT_W-1:0] r_cnt_s, r_cnt_n, r_i, r_j;
    logic [7:0]       r_lab, r_dst;
    logic             r_pend_v;
    logic [7:0]       r_pend_cat, r_pend_nxt;

    // Registered read data
    logic [15:0]      r_arc_q;
    logic [CNT_W-1:0] r_cnt_rd;
    logic             r_cnt_rv;
    logic             r_flag_q;
    logic [CNT_W-1:0] cnt_q;

    // Output register
    logic        r_ovalid, r_olast, r_oempty, r_ostat;
    logic [7:0]  r_ocat, r_onxt;

    // Strobes from the output decoder
    logic             out_free, emit_ok;
    logic             cnt_re, arc_re, flg_re;
    logic [SID_W-1:0] cnt_ra;
    logic [ADDR_W-1:0] arc_ra;
    logic [CAT_W-1:0] flg_ra;
    logic             cnt_we, flg_we;
    logic             push, push_last, push_empty, push_stat;
    logic [7:0]       push_cat, push_nxt;
    logic             pend_load;
    logic [7:0]       pend_cat, pend_nxt;
    logic             app_ok, lab_noise;

    assign cnt_q     = r_cnt_rv ? r_cnt_rd : '0;
    assign out_free  = !r_ovalid || m_axis_tready;
    assign emit_ok   = !r_pend_v || out_free;
    assign app_ok    = f_sid_ok(r_sid) && (cnt_q < CNT_W'(MAX_ARCS));
    assign lab_noise = f_cat_ok(r_lab) && r_flag_q;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        CMD_APPEND: n_state = ST_APP_RD;
                        CMD_NOISE:  n_state = ST_FLAG;
                        CMD_QUERY:  n_state = f_sid_ok(s_axis_tdata[7:0]) ? ST_Q_CNT
                                                                          : ST_Q_FIN;
                        default:    n_state = ST_RESP;
                    endcase
                end
            end
            ST_APP_RD:  n_state = ST_APP_WR;
            ST_APP_WR:  n_state = ST_RESP;
            ST_FLAG:    n_state = ST_RESP;
            ST_RESP:    if (out_free) n_state = ST_IDLE;
            ST_Q_CNT:   n_state = ST_Q_CNT_W;
            ST_Q_CNT_W: n_state = ST_Q_ARC;
            ST_Q_ARC:   n_state = (r_i < r_cnt_s) ? ST_Q_LAB : ST_Q_FIN;
            ST_Q_LAB:   n_state = ST_Q_CLS;
            ST_Q_CLS: begin
                if (lab_noise) begin
                    n_state = f_sid_ok(r_dst) ? ST_Q_NCNT : ST_Q_ARC;
                end else if (emit_ok) begin
                    n_state = ST_Q_ARC;
                end
            end
            ST_Q_NCNT:  n_state = ST_Q_NARC;
            ST_Q_NARC:  n_state = (r_j < r_cnt_n) ? ST_Q_NDAT : ST_Q_ARC;
            ST_Q_NDAT:  if (emit_ok) n_state = ST_Q_NARC;
            ST_Q_FIN:   if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        cnt_re     = 1'b0;
        cnt_ra     = r_sid[SID_W-1:0];
        arc_re     = 1'b0;
        arc_ra     = f_arc_addr(r_sid[SID_W-1:0], r_i);
        flg_re     = 1'b0;
        flg_ra     = r_arc_q[CAT_W-1:0];
        cnt_we     = 1'b0;
        flg_we     = 1'b0;
        push       = 1'b0;
        push_last  = 1'b0;
        push_empty = 1'b0;
        push_stat  = 1'b0;
        push_cat   = r_pend_cat;
        push_nxt   = r_pend_nxt;
        pend_load  = 1'b0;
        pend_cat   = r_lab;
        pend_nxt   = r_dst;
        case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_APP_RD: cnt_re = 1'b1;
            ST_APP_WR: cnt_we = app_ok;
            ST_FLAG:   flg_we = f_cat_ok(r_cat);
            ST_RESP: begin
                push      = out_free;
                push_last = 1'b1;
                push_stat = r_stat;
                push_cat  = '0;
                push_nxt  = '0;
            end
            ST_Q_CNT:  cnt_re = 1'b1;
            ST_Q_ARC:  arc_re = (r_i < r_cnt_s);
            ST_Q_LAB:  flg_re = 1'b1;
            ST_Q_CLS: begin
                if (lab_noise) begin
                    cnt_re = f_sid_ok(r_dst);
                    cnt_ra = r_dst[SID_W-1:0];
                end else if (emit_ok) begin
                    push      = r_pend_v;
                    pend_load = 1'b1;
                end
            end
            ST_Q_NARC: begin
                arc_re = (r_j < r_cnt_n);
                arc_ra = f_arc_addr(r_dst[SID_W-1:0], r_j);
            end
            ST_Q_NDAT: begin
                pend_cat = r_arc_q[7:0];
                pend_nxt = r_arc_q[15:8];
                if (emit_ok) begin
                    push      = r_pend_v;
                    pend_load = 1'b1;
                end
            end
            ST_Q_FIN: begin
                push       = out_free;
                push_last  = 1'b1;
                push_empty = !r_pend_v;
                if (!r_pend_v) begin
                    push_cat = '0;
                    push_nxt = '0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_pend_v  <= 1'b0;
            r_cnt_vld <= '0;
            r_noise   <= '0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_IDLE) begin
                r_pend_v <= 1'b0;
            end else if (pend_load) begin
                r_pend_v <= 1'b1;
            end
            if (cnt_we) begin
                r_cnt_vld[r_sid[SID_W-1:0]] <= 1'b1;
            end
            if (flg_we) begin
                r_noise[r_cat[CAT_W-1:0]] <= r_nz;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= s_axis_tuser;
            r_sid <= s_axis_tdata[7:0];
            r_cat <= s_axis_tdata[15:8];
            r_tgt <= s_axis_tdata[23:16];
            r_nz  <= s_axis_tdata[24];
            r_stat <= 1'b0;
        end
        if (r_state == ST_APP_WR) begin
            r_stat <= !app_ok;
        end
        if (r_state == ST_Q_CNT_W) begin
            r_cnt_s <= cnt_q;
            r_i     <= '0;
        end
        if (r_state == ST_Q_LAB) begin
            r_lab <= r_arc_q[7:0];
            r_dst <= r_arc_q[15:8];
        end
        // An arc is finished when it is emitted, skipped or fully expanded
        if ((r_state == ST_Q_CLS && n_state == ST_Q_ARC) ||
            (r_state == ST_Q_NARC && n_state == ST_Q_ARC)) begin
            r_i <= r_i + CNT_W'(1);
        end
        if (r_state == ST_Q_NCNT) begin
            r_cnt_n <= cnt_q;
            r_j     <= '0;
        end
        if (r_state == ST_Q_NDAT && emit_ok) begin
            r_j <= r_j + CNT_W'(1);
        end
        if (pend_load) begin
            r_pend_cat <= pend_cat;
            r_pend_nxt <= pend_nxt;
        end
        if (push) begin
            r_ocat   <= push_cat;
            r_onxt   <= push_nxt;
            r_olast  <= push_last;
            r_oempty <= push_empty;
            r_ostat  <= push_stat && (r_cmd == CMD_APPEND);
        end
    end

    // Arc memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_arc[f_arc_addr(r_sid[SID_W-1:0], cnt_q)] <= {r_tgt, r_cat};
        end
        if (arc_re) begin
            r_arc_q <= mem_arc[arc_ra];
        end
    end

    // Arc count memory; entries never written read as zero through r_cnt_vld
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[r_sid[SID_W-1:0]] <= cnt_q + CNT_W'(1);
        end
        if (cnt_re) begin
            r_cnt_rd <= mem_cnt[cnt_ra];
            r_cnt_rv <= r_cnt_vld[cnt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (flg_re) begin
            r_flag_q <= r_noise[flg_ra];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_onxt, r_ocat};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = {r_ostat, r_oempty};

endmodule : grammar_next_category_lookup_top
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grammar next-category lookup block. Items of
// arc appends, noise-flag writes, state queries and the unused command are
// streamed in under changing idle and stall patterns. A local copy of the
// arc store predicts every result, and each returned result is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import gncl_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 50;
    localparam int MAX_PRINTED    = 100;
    localparam int N_STATES       = DEF_NUM_STATES;
    localparam int N_CATS         = DEF_NUM_CATEGORIES;
    localparam int N_ARCS         = DEF_MAX_ARCS;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] category;
        logic [7:0] next_state;
        logic       last;
        logic       empty;
        logic       status;
    } t_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    // shadow of the automaton
    logic [7:0]  arc_label  [N_STATES*N_ARCS];
    logic [7:0]  arc_target [N_STATES*N_ARCS];
    int unsigned arc_total  [N_STATES];
    logic        cat_is_noise [N_CATS];

    t_reply expected_replies [$];

    int err_count     = 0;
    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int rx_hold_len   = 0;
    int rx_hold_left  = 0;
    int quiet_cycles  = 0;

    grammar_next_category_lookup_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic report_error(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("ERROR %0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            report_error($sformatf("%s: expected %0d, got %0d", name, want, got));
        end
    endtask

    // Works out the results of one accepted item and updates the shadow store.
    function automatic void predict_lookup(logic [1:0] cmd, logic [7:0] sid,
                                           logic [7:0] cat, logic [7:0] tgt,
                                           logic nz);
        t_reply batch [$];
        t_reply r;
        int     slot;
        int     ns;
        r      = '0;
        r.last = 1'b1;
        case (cmd)
            CMD_APPEND: begin
                if (arc_total[sid] < N_ARCS) begin
                    slot = int'(sid) * N_ARCS + int'(arc_total[sid]);
                    arc_label[slot]  = cat;
                    arc_target[slot] = tgt;
                    arc_total[sid]++;
                end else begin
                    r.status = 1'b1;
                end
                batch.push_back(r);
            end
            CMD_NOISE: begin
                cat_is_noise[cat] = nz;
                batch.push_back(r);
            end
            CMD_QUERY: begin
                for (int i = 0; i < arc_total[sid]; i++) begin
                    slot = int'(sid) * N_ARCS + i;
                    if (cat_is_noise[arc_label[slot]]) begin
                        // noise arc: list the target's arcs as stored, no deeper
                        ns = int'(arc_target[slot]);
                        for (int j = 0; j < arc_total[ns]; j++) begin
                            r            = '0;
                            r.category   = arc_label[ns*N_ARCS + j];
                            r.next_state = arc_target[ns*N_ARCS + j];
                            batch.push_back(r);
                        end
                    end else begin
                        r            = '0;
                        r.category   = arc_label[slot];
                        r.next_state = arc_target[slot];
                        batch.push_back(r);
                    end
                end
                if (batch.size() == 0) begin
                    r       = '0;
                    r.last  = 1'b1;
                    r.empty = 1'b1;
                    batch.push_back(r);
                end else begin
                    r      = batch.pop_back();
                    r.last = 1'b1;
                    batch.push_back(r);
                end
            end
            default: begin
                batch.push_back(r);
            end
        endcase
        foreach (batch[k]) begin
            expected_replies.push_back(batch[k]);
        end
    endfunction

    // Called and returns at a falling edge; valid stays high after the item.
    task automatic send_item(logic [1:0] cmd, logic [7:0] sid, logic [7:0] cat,
                             logic [7:0] tgt, logic nz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {7'b0, nz, tgt, cat, sid};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_lookup(cmd, sid, cat, tgt, nz);
        @(negedge i_clk);
    endtask

    task automatic drain_replies();
        s_axis_tvalid = 1'b0;
        while (expected_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Mostly a small hot set so arc lists fill up and noise flags hit labels.
    function automatic logic [7:0] pick_hot_value(int hot_max);
        if ($urandom_range(99) < 65) begin
            return 8'($urandom_range(hot_max));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic test_directed_arcs();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        send_item(CMD_QUERY,  8'd5,   8'd0,   8'd0,   1'b0);
        send_item(CMD_APPEND, 8'd0,   8'd0,   8'd255, 1'b0);
        send_item(CMD_APPEND, 8'd255, 8'd255, 8'd0,   1'b1);
        send_item(CMD_QUERY,  8'd0,   8'd255, 8'd255, 1'b1);
        send_item(CMD_QUERY,  8'd255, 8'd0,   8'd0,   1'b0);
        drain_replies();
    endtask

    task automatic test_noise_expansion();
        send_item(CMD_NOISE,  8'd0,   8'd255, 8'd0,   1'b1);
        send_item(CMD_QUERY,  8'd255, 8'd0,   8'd0,   1'b0);
        // both labels noise: expansion must stop after one level
        send_item(CMD_NOISE,  8'd255, 8'd0,   8'd255, 1'b1);
        send_item(CMD_QUERY,  8'd0,   8'd0,   8'd0,   1'b0);
        send_item(CMD_NOISE,  8'd0,   8'd0,   8'd0,   1'b0);
        send_item(CMD_NOISE,  8'd0,   8'd255, 8'd0,   1'b0);
        // noise arc into an empty state gives an empty answer
        send_item(CMD_APPEND, 8'd2,   8'd200, 8'd3,   1'b0);
        send_item(CMD_NOISE,  8'd0,   8'd200, 8'd0,   1'b1);
        send_item(CMD_QUERY,  8'd2,   8'd0,   8'd0,   1'b0);
        drain_replies();
    endtask

    task automatic test_full_arc_list();
        for (int k = 0; k <= N_ARCS; k++) begin
            send_item(CMD_APPEND, 8'd1, 8'(10 + k), 8'(k * 31), 1'(k));
        end
        send_item(CMD_QUERY, 8'd1, 8'd0, 8'd0, 1'b0);
        drain_replies();
    endtask

    task automatic test_unused_command();
        send_item(CMD_UNUSED, 8'd255, 8'd255, 8'd255, 1'b1);
        drain_replies();
    endtask

    // Receiver holds off while the sender keeps offering, including the
    // widest possible answer: every arc noise, every target list full.
    task automatic test_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        rx_hold_len   = 400;
        for (int k = 0; k < N_ARCS; k++) begin
            send_item(CMD_APPEND, 8'd4, 8'd201, 8'd1, 1'b0);
        end
        send_item(CMD_NOISE, 8'd0, 8'd201, 8'd0, 1'b1);
        send_item(CMD_QUERY, 8'd4, 8'd0,   8'd0, 1'b0);
        send_item(CMD_QUERY, 8'd1, 8'd0,   8'd0, 1'b0);
        send_item(CMD_NOISE, 8'd0, 8'd201, 8'd0, 1'b0);
        drain_replies();
    endtask

    task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
        logic [1:0] cmd;
        int         pick;
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                cmd = CMD_APPEND;
            end else if (pick < 55) begin
                cmd = CMD_NOISE;
            end else if (pick < 95) begin
                cmd = CMD_QUERY;
            end else begin
                cmd = CMD_UNUSED;
            end
            send_item(cmd, pick_hot_value(31), pick_hot_value(15), pick_hot_value(31),
                      1'($urandom_range(1)));
        end
        drain_replies();
    endtask

    // result side: random stalls, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (rx_hold_len != 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left != 0) begin
            m_axis_tready = 1'b0;
            rx_hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                report_error($sformatf("result with none expected: tdata %h tuser %b",
                                       m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_replies.pop_front();
                check_field("out_category",   want.category,   m_axis_tdata[7:0]);
                check_field("out_next_state", want.next_state, m_axis_tdata[15:8]);
                check_field("last",           want.last,       m_axis_tlast);
                check_field("empty_res",      want.empty,      m_axis_tuser[0]);
                check_field("status",         want.status,     m_axis_tuser[1]);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR %0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < N_STATES; k++) begin
            arc_total[k] = 0;
        end
        for (int k = 0; k < N_CATS; k++) begin
            cat_is_noise[k] = 1'b0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_arcs();
        test_noise_expansion();
        test_full_arc_list();
        test_unused_command();
        test_backpressure();
        test_random_traffic(100, 0,  0);
        test_random_traffic(100, 81, 0);
        test_random_traffic(100, 0,  81);
        test_random_traffic(100, 34, 34);

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule : tb_top

// ----- sim.f -----
rtl/core/gncl_pkg.sv
rtl/core/grammar_next_category_lookup_top.sv
bench/tb_top.sv
